### design/assert_macros.svh
// Assertion macros shared by the deframer RTL.
// Depends on nothing; include by bare file name inside a module body.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is active.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is active.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/tpmd_pkg.sv
// Types and constants for the typed packet message deframer.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tpmd_pkg;

  // Parser phase
  typedef enum logic [2:0] {
    PH_CMD     = 3'd0,
    PH_COUNT   = 3'd1,
    PH_TYPE    = 3'd2,
    PH_SIZE_HI = 3'd3,
    PH_SIZE_LO = 3'd4,
    PH_DATA    = 3'd5
  } phase_t;

  // Result event kinds
  typedef enum logic [1:0] {
    EV_MSG  = 2'd0,
    EV_PKT  = 2'd1,
    EV_WORD = 2'd2,
    EV_BYTE = 2'd3
  } event_kind_t;

  localparam logic [1:0] WORD_LAST_POS = 2'd3;

endpackage

`default_nettype wire

### design/typed_packet_message_deframer.sv
// Latency: a result is registered and shown the cycle after its byte is accepted.
// Throughput: one byte per cycle unless stalled; the parser state updates in a
// single pass per byte and the output register frees in the cycle its transaction
// is taken. Reset: synchronous active-low rst_n; parser returns to expecting a
// command byte, held fields and string type code clear to zero, no result pending.
// Depends on tpmd_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none

module typed_packet_message_deframer (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  // configuration write
  input  wire logic                     cfg_valid,
  output logic                          cfg_ready,
  input  wire logic [7:0]               cfg_string_type_code,
  // received bytes
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire logic [7:0]               in_rx_byte,
  // parse results
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output tpmd_pkg::event_kind_t         out_event_kind,
  output logic [7:0]                    out_command_code,
  output logic [7:0]                    out_packet_total,
  output logic [7:0]                    out_packet_number,
  output logic [7:0]                    out_packet_kind,
  output logic [15:0]                   out_packet_bytes,
  output logic [31:0]                   out_data_value,
  output logic                          out_ends_packet,
  output logic                          out_ends_message
);
  import tpmd_pkg::*;

  // Parser state
  phase_t      phase_r, phase_nxt;
  logic [7:0]  string_code_r;
  logic [7:0]  cmd_r, cmd_nxt;
  logic [7:0]  total_r, total_nxt;
  logic [7:0]  num_r, num_nxt;
  logic [7:0]  kind_r, kind_nxt;
  logic [15:0] bytes_r, bytes_nxt;
  logic [15:0] left_r, left_nxt;
  logic [23:0] gather_r, gather_nxt;
  logic [1:0]  pos_r, pos_nxt;

  // Output register
  logic        out_valid_r, out_valid_nxt;
  event_kind_t ev_r;
  logic [7:0]  ocmd_r, ototal_r, onum_r, okind_r;
  logic [15:0] obytes_r;
  logic [31:0] oval_r;
  logic        oendp_r, oendm_r;

  // Per-byte decode
  logic        in_fire;
  logic        emit;
  event_kind_t ev;
  logic [31:0] val;
  logic        endp, endm;
  logic [7:0]  num_emit;
  logic [15:0] size_full;
  logic        size_zero;
  logic        last_byte;
  logic        word_mode;
  logic        data_emit;
  logic [7:0]  num_inc;
  logic        msg_done;

  assign in_ready  = !out_valid_r || out_ready;
  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  assign size_full = {bytes_r[15:8], in_rx_byte};
  assign size_zero = (size_full == 16'd0);
  assign last_byte = (left_r <= 16'd1);
  // whole-word region: non-string packet, more bytes remain than the trailing remainder
  assign word_mode = (kind_r != string_code_r) && (left_r > {14'd0, bytes_r[1:0]});
  assign data_emit = !word_mode || (pos_r == WORD_LAST_POS);
  assign num_inc   = num_r + 8'd1;
  assign msg_done  = (num_inc == total_r);

  // Next-state logic
  always_comb begin
    phase_nxt  = phase_r;
    cmd_nxt    = cmd_r;
    total_nxt  = total_r;
    num_nxt    = num_r;
    kind_nxt   = kind_r;
    bytes_nxt  = bytes_r;
    left_nxt   = left_r;
    gather_nxt = gather_r;
    pos_nxt    = pos_r;
    unique case (phase_r)
      PH_COUNT: begin
        total_nxt  = in_rx_byte;
        num_nxt    = 8'd0;
        kind_nxt   = 8'd0;
        bytes_nxt  = 16'd0;
        left_nxt   = 16'd0;
        gather_nxt = 24'd0;
        pos_nxt    = 2'd0;
        phase_nxt  = (in_rx_byte == 8'd0) ? PH_CMD : PH_TYPE;
      end
      PH_TYPE: begin
        kind_nxt  = in_rx_byte;
        phase_nxt = PH_SIZE_HI;
      end
      PH_SIZE_HI: begin
        bytes_nxt = {in_rx_byte, 8'd0};
        phase_nxt = PH_SIZE_LO;
      end
      PH_SIZE_LO: begin
        bytes_nxt  = size_full;
        left_nxt   = size_full;
        gather_nxt = 24'd0;
        pos_nxt    = 2'd0;
        if (size_zero) begin
          num_nxt   = num_inc;
          phase_nxt = msg_done ? PH_CMD : PH_TYPE;
        end else begin
          phase_nxt = PH_DATA;
        end
      end
      PH_DATA: begin
        left_nxt = left_r - 16'd1;
        if (word_mode) begin
          if (pos_r == WORD_LAST_POS) begin
            gather_nxt = 24'd0;
            pos_nxt    = 2'd0;
          end else begin
            gather_nxt = {gather_r[15:0], in_rx_byte};
            pos_nxt    = pos_r + 2'd1;
          end
        end
        if (data_emit && last_byte) begin
          num_nxt    = num_inc;
          gather_nxt = 24'd0;
          pos_nxt    = 2'd0;
          phase_nxt  = msg_done ? PH_CMD : PH_TYPE;
        end
      end
      default: begin
        // command byte, also recovery from an unused phase code
        cmd_nxt   = in_rx_byte;
        phase_nxt = PH_COUNT;
      end
    endcase
  end

  // Result decode
  always_comb begin
    emit     = 1'b0;
    ev       = EV_MSG;
    val      = 32'd0;
    endp     = 1'b0;
    endm     = 1'b0;
    num_emit = num_r;
    unique case (phase_r)
      PH_COUNT: begin
        emit     = 1'b1;
        endm     = (in_rx_byte == 8'd0);
        num_emit = 8'd0;
      end
      PH_SIZE_LO: begin
        emit = 1'b1;
        ev   = EV_PKT;
        endp = size_zero;
        endm = size_zero && msg_done;
      end
      PH_DATA: begin
        emit = data_emit;
        if (word_mode) begin
          ev  = EV_WORD;
          val = {gather_r, in_rx_byte};
        end else begin
          ev  = EV_BYTE;
          val = {24'd0, in_rx_byte};
        end
        endp = last_byte;
        endm = last_byte && msg_done;
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  assign out_valid_nxt = in_ready ? (in_fire && emit) : out_valid_r;

  // Control and parser registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_CMD;
      string_code_r <= 8'd0;
      cmd_r         <= 8'd0;
      total_r       <= 8'd0;
      num_r         <= 8'd0;
      kind_r        <= 8'd0;
      bytes_r       <= 16'd0;
      left_r        <= 16'd0;
      gather_r      <= 24'd0;
      pos_r         <= 2'd0;
      out_valid_r   <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        string_code_r <= cfg_string_type_code;
      end
      if (in_fire) begin
        phase_r  <= phase_nxt;
        cmd_r    <= cmd_nxt;
        total_r  <= total_nxt;
        num_r    <= num_nxt;
        kind_r   <= kind_nxt;
        bytes_r  <= bytes_nxt;
        left_r   <= left_nxt;
        gather_r <= gather_nxt;
        pos_r    <= pos_nxt;
      end
    end
  end

  // Result payload register
  always_ff @(posedge clk) begin
    if (in_fire && emit) begin
      ev_r     <= ev;
      ocmd_r   <= cmd_nxt;
      ototal_r <= total_nxt;
      onum_r   <= num_emit;
      okind_r  <= kind_nxt;
      obytes_r <= bytes_nxt;
      oval_r   <= val;
      oendp_r  <= endp;
      oendm_r  <= endm;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_event_kind    = ev_r;
  assign out_command_code  = ocmd_r;
  assign out_packet_total  = ototal_r;
  assign out_packet_number = onum_r;
  assign out_packet_kind   = okind_r;
  assign out_packet_bytes  = obytes_r;
  assign out_data_value    = oval_r;
  assign out_ends_packet   = oendp_r;
  assign out_ends_message  = oendm_r;

  // Assertions
  `include "assert_macros.svh"

  `ASSERT_IMPLY(a_endm_needs_endp, clk, rst_n,
    out_valid_r && oendm_r, oendp_r || (ev_r == EV_MSG), "message end without packet end")
  `ASSERT_IMPLY(a_data_left_nonzero, clk, rst_n,
    phase_r == PH_DATA, left_r != 16'd0, "data phase with no bytes left")
  `ASSERT_IMPLY(a_gather_only_in_data, clk, rst_n,
    pos_r != 2'd0, phase_r == PH_DATA, "word gather active outside data phase")
  `ASSERT_NEXT(a_last_byte_leaves_data, clk, rst_n,
    in_fire && (phase_r == PH_DATA) && (left_r == 16'd1),
    (phase_r == PH_CMD) || (phase_r == PH_TYPE), "packet did not close on last byte")

endmodule

`default_nettype wire
